### design/eld_pkg.sv
// Shared types for the execution loop detector.
package eld_pkg;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_FILL,
      ST_COMMIT,
      ST_CMP,
      ST_CMP_END
   } eld_state_type;

endpackage

### design/eld_ram.sv
// Generic RAM: one write port, two registered read ports.
module eld_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 2112
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_a_addr,
   output logic [WIDTH-1:0]         rd_a_data,
   input  logic [$clog2(DEPTH)-1:0] rd_b_addr,
   output logic [WIDTH-1:0]         rd_b_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_a_data <= mem_ff[rd_a_addr];
      rd_b_data <= mem_ff[rd_b_addr];
   end

endmodule

### design/execution_loop_detector.sv
// Execution loop detector: snapshot history store and periodicity check.
//
// Snapshot words (program counter, then REGISTER_COUNT registers) are taken one
// per cycle on start while busy is low. A word without req_word_last gives no
// result. On the last word the block goes busy: it zero-fills any missing words
// of the snapshot (one per cycle), commits it, then, once two entries are held,
// compares whole history entries through the two read ports of one history
// RAM. The search compares entry 0 against entries 1..p (p the period found, or
// count/2), and a found period adds up to p more pair compares. The answer
// appears on rsp_loop_found with rsp_valid high for exactly one cycle; the
// receiver cannot stall it, and busy drops in that same cycle.
module execution_loop_detector
   import eld_pkg::*;
#(
   parameter int HISTORY_DEPTH  = 64,
   parameter int REGISTER_COUNT = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [31:0] req_word_value,
   input  logic        req_word_last,
   output logic        rsp_valid,
   output logic        rsp_loop_found
);

   localparam int SNAP_WORDS = REGISTER_COUNT + 1;
   localparam int DEPTH      = HISTORY_DEPTH * SNAP_WORDS;
   localparam int AW         = $clog2(DEPTH);
   localparam int WP_W       = $clog2(SNAP_WORDS + 1);
   localparam int CNT_W      = $clog2(HISTORY_DEPTH + 1);
   localparam int LAST_BASE  = (HISTORY_DEPTH - 1) * SNAP_WORDS;

   localparam logic [AW-1:0]    SW_A      = AW'(SNAP_WORDS);
   localparam logic [AW-1:0]    LAST_A    = AW'(LAST_BASE);
   localparam logic [WP_W-1:0]  SW_P      = WP_W'(SNAP_WORDS);
   localparam logic [WP_W-1:0]  SW_LAST_P = WP_W'(SNAP_WORDS - 1);
   localparam logic [CNT_W-1:0] HD_C      = CNT_W'(HISTORY_DEPTH);

   eld_state_type    state_ff, state_in;
   logic [WP_W-1:0]  wp_ff, wp_in;
   logic [AW-1:0]    newest_base_ff, newest_base_in;
   logic [AW-1:0]    fill_base_ff, fill_base_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic             rsp_found_ff, rsp_found_in;

   logic [AW-1:0]    a_base_ff, a_base_in;
   logic [AW-1:0]    b_base_ff, b_base_in;
   logic [WP_W-1:0]  widx_ff, widx_in;
   logic [CNT_W-1:0] j_ff, j_in;
   logic [CNT_W-1:0] half_ff, half_in;
   logic [CNT_W-1:0] period_ff, period_in;
   logic             verify_ff, verify_in;
   logic             eq_ff, eq_in;
   logic             pend_ff;

   logic             wr_en;
   logic [AW-1:0]    wr_addr;
   logic [31:0]      wr_data;
   logic [AW-1:0]    rd_a_addr, rd_b_addr;
   logic [31:0]      rd_a_data, rd_b_data;

   logic             accept;
   logic [WP_W-1:0]  wp_next;
   logic [CNT_W-1:0] count_new;
   logic             match;
   logic [AW-1:0]    a_dec, b_dec;

   eld_ram #(
      .WIDTH (32),
      .DEPTH (DEPTH)
   ) u_store (
      .clock     (clock),
      .wr_en     (wr_en),
      .wr_addr   (wr_addr),
      .wr_data   (wr_data),
      .rd_a_addr (rd_a_addr),
      .rd_a_data (rd_a_data),
      .rd_b_addr (rd_b_addr),
      .rd_b_data (rd_b_data)
   );

   assign busy           = (state_ff != ST_IDLE);
   assign accept         = start && !busy;
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_loop_found = rsp_found_ff;

   assign wr_addr   = fill_base_ff + AW'(wp_ff);
   assign rd_a_addr = a_base_ff + AW'(widx_ff);
   assign rd_b_addr = b_base_ff + AW'(widx_ff);
   assign match     = eq_ff && (rd_a_data == rd_b_data);
   assign a_dec     = (a_base_ff == '0) ? LAST_A : a_base_ff - SW_A;
   assign b_dec     = (b_base_ff == '0) ? LAST_A : b_base_ff - SW_A;
   assign count_new = (count_ff < HD_C) ? count_ff + 1'b1 : count_ff;
   assign wp_next   = (wp_ff < SW_P) ? wp_ff + 1'b1 : wp_ff;

   always_comb begin
      state_in       = state_ff;
      wp_in          = wp_ff;
      newest_base_in = newest_base_ff;
      fill_base_in   = fill_base_ff;
      count_in       = count_ff;
      rsp_valid_in   = 1'b0;
      rsp_found_in   = rsp_found_ff;
      a_base_in      = a_base_ff;
      b_base_in      = b_base_ff;
      widx_in        = widx_ff;
      j_in           = j_ff;
      half_in        = half_ff;
      period_in      = period_ff;
      verify_in      = verify_ff;
      eq_in          = eq_ff;
      wr_en          = 1'b0;
      wr_data        = req_word_value;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               wr_en = (wp_ff < SW_P);
               wp_in = wp_next;
               if (req_word_last) begin
                  state_in = (wp_next < SW_P) ? ST_FILL : ST_COMMIT;
               end
            end
         end
         ST_FILL: begin
            wr_en   = 1'b1;
            wr_data = '0;
            wp_in   = wp_ff + 1'b1;
            if (wp_ff == SW_LAST_P) begin
               state_in = ST_COMMIT;
            end
         end
         ST_COMMIT: begin
            newest_base_in = fill_base_ff;
            fill_base_in   = (fill_base_ff == LAST_A) ? '0 : fill_base_ff + SW_A;
            count_in       = count_new;
            wp_in          = '0;
            a_base_in      = fill_base_ff;
            b_base_in      = (fill_base_ff == '0) ? LAST_A : fill_base_ff - SW_A;
            half_in        = count_new >> 1;
            j_in           = CNT_W'(1);
            verify_in      = 1'b0;
            widx_in        = '0;
            eq_in          = 1'b1;
            if (count_new < CNT_W'(2)) begin
               rsp_valid_in = 1'b1;
               rsp_found_in = 1'b0;
               state_in     = ST_IDLE;
            end else begin
               state_in = ST_CMP;
            end
         end
         ST_CMP: begin
            eq_in   = eq_ff && (!pend_ff || (rd_a_data == rd_b_data));
            widx_in = widx_ff + 1'b1;
            if (widx_ff == SW_LAST_P) begin
               widx_in  = '0;
               state_in = ST_CMP_END;
            end
         end
         ST_CMP_END: begin
            eq_in    = 1'b1;
            state_in = ST_CMP;
            if (!verify_ff) begin
               if (match) begin
                  period_in = j_ff;
                  j_in      = '0;
                  verify_in = 1'b1;
                  a_base_in = newest_base_ff;
               end else if (j_ff == half_ff) begin
                  rsp_valid_in = 1'b1;
                  rsp_found_in = 1'b0;
                  state_in     = ST_IDLE;
               end else begin
                  j_in      = j_ff + 1'b1;
                  b_base_in = b_dec;
               end
            end else begin
               if (!match) begin
                  rsp_valid_in = 1'b1;
                  rsp_found_in = 1'b0;
                  state_in     = ST_IDLE;
               end else if (j_ff + 1'b1 == period_ff) begin
                  rsp_valid_in = 1'b1;
                  rsp_found_in = 1'b1;
                  state_in     = ST_IDLE;
               end else begin
                  j_in      = j_ff + 1'b1;
                  a_base_in = a_dec;
                  b_base_in = b_dec;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         wp_ff          <= '0;
         newest_base_ff <= '0;
         fill_base_ff   <= SW_A;
         count_ff       <= '0;
         rsp_valid_ff   <= 1'b0;
         pend_ff        <= 1'b0;
      end else begin
         state_ff       <= state_in;
         wp_ff          <= wp_in;
         newest_base_ff <= newest_base_in;
         fill_base_ff   <= fill_base_in;
         count_ff       <= count_in;
         rsp_valid_ff   <= rsp_valid_in;
         pend_ff        <= (state_ff == ST_CMP);
      end
   end

   always_ff @(posedge clock) begin
      rsp_found_ff <= rsp_found_in;
      a_base_ff    <= a_base_in;
      b_base_ff    <= b_base_in;
      widx_ff      <= widx_in;
      j_ff         <= j_in;
      half_ff      <= half_in;
      period_ff    <= period_in;
      verify_ff    <= verify_in;
      eq_ff        <= eq_in;
   end

endmodule

### sim/tb.sv
// Self-checking testbench for execution_loop_detector: directed table, then random snapshot runs.
module tb;

   localparam int HIST        = 64;
   localparam int NREG        = 32;
   localparam int SNAPW       = NREG + 1;
   localparam int ITEMS       = 1200;
   localparam int MAX_LATENCY = HIST * (NREG + 2) + SNAPW + 16;
   localparam int LIMIT       = 20000000;
   localparam int MAX_PERIOD  = 24;

   typedef logic [31:0] word_q_type[$];

   typedef struct packed {
      logic [31:0] value;
      logic        last;
      logic        typed;
      logic        loop;
   } stim_row_type;

   // typed verdicts only where the history is trivial; the rest go to the predictor
   localparam int DIRECTED_ROWS = 17;
   localparam stim_row_type DIRECTED [DIRECTED_ROWS] = '{
      '{32'h0000_0000, 1'b1, 1'b1, 1'b0},
      '{32'h0000_0000, 1'b1, 1'b1, 1'b1},
      '{32'hFFFF_FFFF, 1'b0, 1'b0, 1'b0},
      '{32'hFFFF_FFFF, 1'b1, 1'b1, 1'b0},
      '{32'hFFFF_FFFF, 1'b0, 1'b0, 1'b0},
      '{32'hFFFF_FFFF, 1'b1, 1'b1, 1'b1},
      '{32'h0000_0000, 1'b0, 1'b0, 1'b0},
      '{32'h8000_0000, 1'b1, 1'b1, 1'b0},
      '{32'h0000_0001, 1'b1, 1'b0, 1'b0},
      '{32'h0000_0000, 1'b0, 1'b0, 1'b0},
      '{32'h8000_0000, 1'b1, 1'b0, 1'b0},
      '{32'h0000_0001, 1'b1, 1'b0, 1'b0},
      '{32'h0000_0000, 1'b0, 1'b0, 1'b0},
      '{32'h8000_0000, 1'b1, 1'b0, 1'b0},
      '{32'hAAAA_AAAA, 1'b0, 1'b0, 1'b0},
      '{32'h5555_5555, 1'b0, 1'b0, 1'b0},
      '{32'hAAAA_AAAA, 1'b1, 1'b0, 1'b0}
   };

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic [31:0] req_word_value = '0;
   logic        req_word_last = 1'b0;
   logic        busy;
   logic        rsp_valid;
   logic        rsp_loop_found;

   execution_loop_detector #(
      .HISTORY_DEPTH (HIST),
      .REGISTER_COUNT(NREG)
   ) uut (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .busy          (busy),
      .req_word_value(req_word_value),
      .req_word_last (req_word_last),
      .rsp_valid     (rsp_valid),
      .rsp_loop_found(rsp_loop_found)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // snapshot history mirror
   logic [31:0] history [HIST][SNAPW];
   int unsigned newest   = 0;
   int unsigned held     = 0;
   int unsigned word_idx = 0;

   bit loop_expected[$];
   int errors       = 0;
   int cycles       = 0;
   int words_sent   = 0;
   int burst_left   = 0;

   function automatic int unsigned slot_at(int unsigned k);
      return (newest + HIST - (k % HIST)) % HIST;
   endfunction

   function automatic bit snapshots_equal(int unsigned a, int unsigned b);
      int unsigned sa, sb;
      sa = slot_at(a);
      sb = slot_at(b);
      for (int w = 0; w < SNAPW; w++)
         if (history[sa][w] != history[sb][w]) return 1'b0;
      return 1'b1;
   endfunction

   function automatic bit detect_loop();
      int unsigned half, period;
      if (held < 2) return 1'b0;
      half = held / 2;
      period = 0;
      for (int unsigned j = 1; j <= half; j++)
         if (snapshots_equal(j, 0)) begin
            period = j;
            break;
         end
      if (period == 0) return 1'b0;
      for (int unsigned j = 0; j < period; j++)
         if (!snapshots_equal(j, j + period)) return 1'b0;
      return 1'b1;
   endfunction

   // returns 1 when the word completes a snapshot; verdict holds the loop answer
   function automatic bit record_word(input logic [31:0] value, input bit last,
                                      output bit verdict);
      int unsigned fill;
      fill = (newest + 1) % HIST;
      verdict = 1'b0;
      if (word_idx < SNAPW) begin
         history[fill][word_idx] = value;
         word_idx++;
      end
      if (!last) return 1'b0;
      while (word_idx < SNAPW) begin
         history[fill][word_idx] = '0;
         word_idx++;
      end
      newest = fill;
      if (held < HIST) held++;
      word_idx = 0;
      verdict = detect_loop();
      return 1'b1;
   endfunction

   task automatic send_word(input logic [31:0] value, input bit last,
                            input bit typed, input bit typed_loop);
      int gap;
      bit verdict;
      if (burst_left == 0) begin
         gap = $urandom_range(1, 6);
         start <= 1'b0;
         req_word_value <= $urandom;
         req_word_last <= $urandom_range(0, 1);
         repeat (gap) @(posedge clock);
         burst_left = ($urandom_range(0, 4) == 0) ? 200 : $urandom_range(1, 40);
      end
      start <= 1'b1;
      req_word_value <= value;
      req_word_last <= last;
      do @(posedge clock); while (busy);
      burst_left--;
      words_sent++;
      if (record_word(value, last, verdict)) begin
         loop_expected.push_back(typed ? typed_loop : verdict);
      end
   endtask

   task automatic send_snapshot(input word_q_type words);
      for (int i = 0; i < words.size(); i++)
         send_word(words[i], i == words.size() - 1, 1'b0, 1'b0);
   endtask

   function automatic logic [31:0] rand_word();
      case ($urandom_range(0, 7))
         0: return '0;
         1: return '1;
         2: return $urandom_range(0, 3);
         default: return $urandom;
      endcase
   endfunction

   function automatic word_q_type make_snapshot(input bit short_only);
      word_q_type words;
      int len, pick;
      pick = short_only ? 9 : $urandom_range(0, 9);
      if (pick < 4) len = SNAPW;
      else if (pick < 5) len = $urandom_range(SNAPW + 1, SNAPW + 7);
      else len = $urandom_range(1, 8);
      for (int i = 0; i < len; i++) words.push_back(rand_word());
      return words;
   endfunction

   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         if (loop_expected.size() == 0) begin
            $display("%0t: unexpected transfer, expected none, got loop_found=%0b",
                     $time, rsp_loop_found);
            errors <= errors + 1;
         end else begin
            if (rsp_loop_found !== loop_expected[0]) begin
               $display("%0t: loop_found mismatch, expected %0b, got %0b",
                        $time, loop_expected[0], rsp_loop_found);
               errors <= errors + 1;
            end
            void'(loop_expected.pop_front());
         end
      end
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   initial begin
      word_q_type pattern [MAX_PERIOD];
      word_q_type snap;
      int period, reps, bad_k, bad_w;
      bit broken;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (int r = 0; r < DIRECTED_ROWS; r++)
         send_word(DIRECTED[r].value, DIRECTED[r].last, DIRECTED[r].typed, DIRECTED[r].loop);

      while (words_sent < ITEMS) begin
         if ($urandom_range(0, 9) < 2) begin
            send_snapshot(make_snapshot(1'b0));
         end else begin
            period = ($urandom_range(0, 3) == 0) ? $urandom_range(5, MAX_PERIOD)
                                                 : $urandom_range(1, 4);
            reps = $urandom_range(2, 3);
            for (int k = 0; k < period; k++) pattern[k] = make_snapshot(period > 4);
            broken = ($urandom_range(0, 2) == 0);
            bad_k = $urandom_range(0, period - 1);
            for (int r = 0; r < reps; r++)
               for (int k = 0; k < period; k++) begin
                  snap = pattern[k];
                  if (broken && r == reps - 1 && k == bad_k) begin
                     bad_w = $urandom_range(0, snap.size() - 1);
                     snap[bad_w] = snap[bad_w] ^ (32'h1 << $urandom_range(0, 31));
                  end
                  send_snapshot(snap);
               end
         end
      end
      start <= 1'b0;

      while (loop_expected.size() != 0) @(posedge clock);
      repeat (MAX_LATENCY) @(posedge clock);
      if (errors == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

endmodule

### sim.f
design/eld_pkg.sv
design/eld_ram.sv
design/execution_loop_detector.sv
sim/tb.sv
